/* rtl/core/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg: shared constants for the bitmap page allocator
// Default geometry, field widths and configuration register indices.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // default geometry
  localparam int unsigned MaxPagesDef = 65536;
  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned PageBitsDef = 12;

  // fixed field widths
  localparam int unsigned SizeW  = 29;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned CntW   = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // configuration register indices
  localparam logic [CfgIdxW-1:0] RegPoolBase  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPoolPages = 2'd1;

endpackage

/* rtl/core/bitmap_page_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator: first-fit single page allocator
// Used-page bitmap in RAM, scanned word by word from word zero.
// ----------------------------------------------------------------------------
// Each nonzero request claims the lowest free page below pool_pages (capped
// at MAX_PAGES) and returns pool_base + (page << PAGE_BITS), wrapping at 2^32;
// a zero size or a full pool returns granted = 0 and address 0. One item is
// in flight at a time. A request of zero size, or with pool_pages zero,
// skips the scan; otherwise the scan reads bitmap words up to and including
// the first word with a free page. The bitmap RAM delivers one word per
// cycle; the set bit is written back in the cycle the free page is found.
// Words beyond the highest word ever written read as free, so no clearing
// pass is needed after reset. The next request is accepted while a result
// awaits transfer. The user must write configuration only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES = bpa_pkg::MaxPagesDef,
  parameter int unsigned WORD_BITS = bpa_pkg::WordBitsDef,
  parameter int unsigned PAGE_BITS = bpa_pkg::PageBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpa_pkg::CfgDataW-1:0]  cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bpa_pkg::SizeW-1:0]     request_size_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          granted_o,
  output logic [bpa_pkg::AddrW-1:0]     page_address_o,
  output logic [bpa_pkg::CntW-1:0]      free_pages_o
);
  import bpa_pkg::*;

  localparam int unsigned MapWords = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIdxW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned BitW     = $clog2(WORD_BITS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // lowest clear bit of a word
  function automatic logic [BitW:0] lowest_clear(input logic [WORD_BITS-1:0] w);
    logic [BitW:0] res;
    res = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        res = {1'b1, BitW'(i)};
      end
    end
    return res;
  endfunction

  // configuration registers
  logic [AddrW-1:0] pool_base_q;
  logic [CntW-1:0]  pool_pages_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_pages_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        RegPoolBase:  pool_base_q  <= cfg_data_i;
        RegPoolPages: pool_pages_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // effective page count
  logic [CntW-1:0] limit;
  assign limit = (pool_pages_q > CntW'(MAX_PAGES)) ? CntW'(MAX_PAGES) : pool_pages_q;

  // scan state
  logic [WIdxW-1:0] word_q, word_d;     // word currently being checked
  logic [CntW-1:0]  pbase_q, pbase_d;   // page index of that word's bit 0
  logic [CntW-1:0]  rem_q, rem_d;       // pages left below the limit from pbase
  logic [WIdxW:0]   hwm_q, hwm_d;       // words ever written
  logic [CntW-1:0]  count_q, count_d;
  logic             grant_q, grant_d;
  logic [AddrW-1:0] addr_q, addr_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             granted_q, granted_d;
  logic [AddrW-1:0] page_address_q, page_address_d;
  logic [CntW-1:0]  free_pages_q, free_pages_d;

  // bitmap RAM
  logic                 ram_we, ram_re;
  logic [WIdxW-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata, ram_wdata;

  bpa_ram #(
    .Width (WORD_BITS),
    .Depth (MapWords),
    .AddrW (WIdxW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // word as seen by the scan: unwritten words are free, pages past limit used
  logic [WORD_BITS-1:0] cur_word, lim_mask, masked;
  logic [BitW:0]        lc;
  logic                 hit, last_word;
  logic [CntW-1:0]      found_idx;
  logic [63:0]          offset;

  always_comb begin
    cur_word = ({1'b0, word_q} < hwm_q) ? ram_rdata : '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      lim_mask[b] = (rem_q <= CntW'(b));
    end
    masked    = cur_word | lim_mask;
    lc        = lowest_clear(masked);
    hit       = lc[BitW];
    last_word = (rem_q <= CntW'(WORD_BITS));
    found_idx = pbase_q + CntW'(lc[BitW-1:0]);
    offset    = 64'(found_idx) << PAGE_BITS;
    ram_wdata = cur_word | (WORD_BITS'(1) << lc[BitW-1:0]);
  end

  logic in_acc, out_free;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // control
  always_comb begin
    state_d        = state_q;
    word_d         = word_q;
    pbase_d        = pbase_q;
    rem_d          = rem_q;
    hwm_d          = hwm_q;
    count_d        = count_q;
    grant_d        = grant_q;
    addr_d         = addr_q;
    out_valid_d    = out_valid_q && out_stall_i;
    granted_d      = granted_q;
    page_address_d = page_address_q;
    free_pages_d   = free_pages_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = WIdxW'(word_q + 1'b1);

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          grant_d = 1'b0;
          addr_d  = '0;
          word_d  = '0;
          pbase_d = '0;
          rem_d   = limit;
          if (request_size_i != '0 && limit != '0) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_d   = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          // claim the page and write the word back
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
          grant_d = 1'b1;
          addr_d  = pool_base_q + offset[AddrW-1:0];
          if ({1'b0, word_q} >= hwm_q) begin
            hwm_d = {1'b0, word_q} + 1'b1;
          end
          state_d = S_DONE;
        end else if (last_word) begin
          state_d = S_DONE;
        end else begin
          ram_re  = 1'b1;
          word_d  = WIdxW'(word_q + 1'b1);
          pbase_d = pbase_q + CntW'(WORD_BITS);
          rem_d   = rem_q - CntW'(WORD_BITS);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          granted_d      = grant_q;
          page_address_d = addr_q;
          free_pages_d   = (limit > count_q) ? (limit - count_q) : '0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hwm_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hwm_q       <= hwm_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    word_q         <= word_d;
    pbase_q        <= pbase_d;
    rem_q          <= rem_d;
    grant_q        <= grant_d;
    addr_q         <= addr_d;
    granted_q      <= granted_d;
    page_address_q <= page_address_d;
    free_pages_q   <= free_pages_d;
  end

  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign page_address_o = page_address_q;
  assign free_pages_o   = free_pages_q;

  // checks
  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_SCAN)
    else $error("bitmap write outside scan");

  a_refused_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> page_address_o == '0)
    else $error("refused result carries an address");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_PAGES))
    else $error("allocation count above pool maximum");

  a_hwm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q <= (WIdxW+1)'(MapWords))
    else $error("high-water mark beyond bitmap");

  a_grant_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> count_q == $past(count_q) + 1'b1)
    else $error("grant not counted");

endmodule

/* rtl/core/bpa_ram.sv */
// ----------------------------------------------------------------------------
// bpa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* test/bitmap_page_allocator_test.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator_test: self-checking bench for the page allocator
// Requests are fed through a random-idling driver and each result is checked
// against a local first-fit bitmap predictor. The pool is reconfigured
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_test;

  import bpa_pkg::*;

  // indices outside the register map, writes must be ignored
  localparam logic [CfgIdxW-1:0] RegUnmappedA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegUnmappedB = 2'd3;

  localparam logic [CntW-1:0] PoolCeiling = 17'd65536;

  typedef struct packed {
    logic            granted;
    logic [AddrW-1:0] page_address;
    logic [CntW-1:0]  free_pages;
  } alloc_result_t;

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                cfg_valid    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx      = '0;
  logic [CfgDataW-1:0] cfg_data     = '0;
  logic                cfg_ready;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [SizeW-1:0]    request_size = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                granted;
  logic [AddrW-1:0]    page_address;
  logic [CntW-1:0]     free_pages;

  // predictor state: used-page bitmap, grant count and pool registers
  bit   [31:0]         page_map [0:2047];
  logic [CntW-1:0]     placed_count = '0;
  logic [AddrW-1:0]    pool_base_q  = '0;
  logic [CntW-1:0]     pool_pages_q = '0;

  logic [SizeW-1:0]    request_backlog [$];
  alloc_result_t       awaited_results [$];
  int                  requests_open = 0;
  int                  mismatches    = 0;
  int                  idle_pct      = 35;

  bitmap_page_allocator u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .request_size_i (request_size),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .granted_o      (granted),
    .page_address_o (page_address),
    .free_pages_o   (free_pages)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // first-fit claim of one page, updates the local bitmap
  function automatic alloc_result_t claim_page(logic [SizeW-1:0] size);
    alloc_result_t   res;
    logic [CntW-1:0] lim;
    logic [CntW-1:0] idx;
    logic            found;
    lim   = (pool_pages_q > PoolCeiling) ? PoolCeiling : pool_pages_q;
    idx   = '0;
    found = 1'b0;
    res   = '0;
    if (size != '0) begin
      while (!found && idx < lim) begin
        // 32-bit map words: upper index bits pick the word
        if (!page_map[idx[15:5]][idx[4:0]]) found = 1'b1;
        else idx = idx + 17'd1;
      end
      if (found) begin
        page_map[idx[15:5]][idx[4:0]] = 1'b1;
        placed_count     = placed_count + 17'd1;
        res.granted      = 1'b1;
        res.page_address = pool_base_q + ({15'd0, idx} << PageBitsDef);
      end
    end
    res.free_pages = (lim > placed_count) ? lim - placed_count : '0;
    return res;
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(19))
      0, 1, 2: return '0;
      3:       return '1;
      4:       return 29'd1;
      default: return r[SizeW-1:0];
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic queue_request(input logic [SizeW-1:0] size);
    request_backlog.push_back(size);
    requests_open++;
  endtask

  // single register transfer, mirrored into the predictor
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegPoolBase:  pool_base_q  = data;
      RegPoolPages: pool_pages_q = data[CntW-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // wait for every queued request to come back, then a short settle
  task automatic drain();
    while (requests_open != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver: hold an item until its transfer, idle at random
  always @(posedge clk) begin : drive_requests
    logic             send;
    logic [SizeW-1:0] next_size;
    send      = in_valid;
    next_size = request_size;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(claim_page(request_size));
        send = 1'b0;
      end
      if (!send && request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_size = request_backlog.pop_front();
        send      = 1'b1;
      end
    end
    in_valid     <= send;
    request_size <= next_size;
  end

  // result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin : watch_results
    alloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = awaited_results.pop_front();
        requests_open--;
        if (granted !== want.granted)
          flag_mismatch($sformatf("granted %b, predicted %b", granted, want.granted));
        if (page_address !== want.page_address)
          flag_mismatch($sformatf("page_address %h, predicted %h",
                                  page_address, want.page_address));
        if (free_pages !== want.free_pages)
          flag_mismatch($sformatf("free_pages %0d, predicted %0d",
                                  free_pages, want.free_pages));
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < idle_pct);
  end

  initial begin : stimulus
    logic [31:0] pages;
    logic [31:0] word;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // empty pool after reset: everything refused
    queue_request(29'd1);
    queue_request('0);
    drain();

    // one-page pool: first grant, then full, then zero size
    write_reg(RegPoolBase, 32'h0000_0000);
    write_reg(RegPoolPages, 32'd1);
    queue_request('1);
    queue_request(29'h1000_0000);
    queue_request('0);
    drain();

    // unmapped indices, masked page count, base near the top so addresses wrap
    write_reg(RegUnmappedA, 32'hFFFF_FFFF);
    write_reg(RegUnmappedB, $urandom);
    write_reg(RegPoolBase, 32'hFFFF_E000);
    write_reg(RegPoolPages, 32'h0002_0023);
    repeat (6) queue_request(pick_size() | 29'd1);
    drain();

    // page count below earlier grants: free count saturates at zero
    write_reg(RegPoolPages, 32'd3);
    queue_request(29'd4096);
    queue_request('0);
    drain();

    // oversized page count is capped
    write_reg(RegPoolPages, 32'h0001_FFFF);
    write_reg(RegPoolBase, 32'h0000_0000);
    repeat (4) queue_request(29'd1);
    drain();

    write_reg(RegPoolPages, 32'd65536);
    write_reg(RegPoolBase, 32'hFFFF_FFFF);
    queue_request(29'd12);
    queue_request('1);
    drain();

    // random phases, each with a fresh pool setting
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(3))
        0:       pages = placed_count + $urandom_range(12);
        1:       pages = $urandom_range(placed_count);
        2:       pages = $urandom_range(131071, 65536);
        default: pages = $urandom_range(65536);
      endcase
      word = $urandom;
      if ($urandom_range(3) == 0) pages = pages | (word & 32'hFFFE_0000);
      write_reg(RegPoolPages, pages);
      if ($urandom_range(3) != 0)
        write_reg(RegPoolBase, ($urandom_range(1) == 1) ? ($urandom | 32'hFFF0_0000) : $urandom);
      if ($urandom_range(4) == 0) write_reg(RegUnmappedA, $urandom);
      // one phase runs with no idling on either side
      idle_pct = (ph == 4) ? 0 : 35;
      repeat (29) queue_request(pick_size());
      drain();
    end

    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_mismatch($sformatf("%0d predicted results never arrived", awaited_results.size()));
    if (mismatches == 0) begin
      $display("bitmap_page_allocator test passed");
    end else begin
      $display("bitmap_page_allocator test failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #30_000_000;
    $display("bitmap_page_allocator test failed");
    $finish;
  end

endmodule
